### src/predicated_accumulator_cpu_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the predicated accumulator step block
// Concurrent checks on a clock with an active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PREDICATED_ACCUMULATOR_CPU_STEP_ASSERT_SVH
`define PREDICATED_ACCUMULATOR_CPU_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pac: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define PAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pac: next-cycle property violated");

`endif

### src/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Types, opcode codes and the instruction decoder of the predicated
// accumulator step block.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int OP_W    = 6;
    localparam int IDX_W   = 5;
    localparam int DATA_W  = 8;
    localparam int FLAG_W  = 4;
    localparam int IP_W    = 8;
    localparam int LEN_W   = 9;
    localparam int NIP_W   = IP_W + 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

    localparam int FAM_COUNT  = 7;
    localparam int FORM_COUNT = 5;

    localparam logic [OP_W-1:0] OP_ALU_FIRST = 6'd1;
    localparam logic [OP_W-1:0] OP_ALU_LAST  = 6'd35;
    localparam logic [OP_W-1:0] OP_INC_R     = 6'd36;
    localparam logic [OP_W-1:0] OP_DEC_R     = 6'd37;
    localparam logic [OP_W-1:0] OP_INC_A     = 6'd38;
    localparam logic [OP_W-1:0] OP_DEC_A     = 6'd39;
    localparam logic [OP_W-1:0] OP_SET_F     = 6'd40;
    localparam logic [OP_W-1:0] OP_CLR_F     = 6'd41;
    localparam logic [OP_W-1:0] OP_JMP_ABS_R = 6'd42;
    localparam logic [OP_W-1:0] OP_JMP_ABS_I = 6'd43;
    localparam logic [OP_W-1:0] OP_JMP_ABS_A = 6'd44;
    localparam logic [OP_W-1:0] OP_JMP_REL_R = 6'd45;
    localparam logic [OP_W-1:0] OP_JMP_REL_I = 6'd46;
    localparam logic [OP_W-1:0] OP_JMP_REL_A = 6'd47;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_ALU,
        CLS_INC_R,
        CLS_DEC_R,
        CLS_INC_A,
        CLS_DEC_A,
        CLS_SET_F,
        CLS_CLR_F,
        CLS_JMP_ABS,
        CLS_JMP_REL
    } op_cls_t;

    typedef enum logic [2:0] {
        FAM_MOV,
        FAM_ADD,
        FAM_SUB,
        FAM_EQ,
        FAM_NE,
        FAM_GT,
        FAM_LT
    } op_fam_t;

    typedef enum logic [2:0] {
        FORM_RI,
        FORM_RR,
        FORM_RA,
        FORM_AR,
        FORM_AI
    } op_form_t;

    typedef enum logic [1:0] {
        JSRC_REG,
        JSRC_IMM,
        JSRC_ACC
    } jmp_src_t;

    typedef struct packed {
        op_cls_t  cls;
        op_fam_t  fam;
        op_form_t form;
        jmp_src_t jsrc;
        logic     need_d;
        logic     need_s;
    } dec_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [IDX_W-1:0]  dest_index;
        logic [IDX_W-1:0]  source_index;
        logic [DATA_W-1:0] immediate;
        logic [FLAG_W-1:0] target_flag_mask;
        logic [FLAG_W-1:0] allow_flag_mask;
        logic [FLAG_W-1:0] deny_flag_mask;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [FLAG_W-1:0] flags;
        logic [IP_W-1:0]   ip;
        logic              halted;
        logic              error;
    } arch_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic [IP_W-1:0]   next_ip;
        logic              halted;
        logic              error;
        logic [DATA_W-1:0] acc_value;
        logic [FLAG_W-1:0] flags_value;
        logic [DATA_W-1:0] dest_value;
    } out_t;

    typedef struct packed {
        arch_t  nxt;
        rf_wr_t wr;
        out_t   res;
    } exec_out_t;

    function automatic dec_t pac_decode(input logic [OP_W-1:0] op);
        dec_t            d;
        logic [OP_W-1:0] rel;
        d.cls    = CLS_NOP;
        d.fam    = FAM_MOV;
        d.form   = FORM_RI;
        d.jsrc   = JSRC_IMM;
        d.need_d = 1'b0;
        d.need_s = 1'b0;
        rel      = op - OP_ALU_FIRST;
        if (op >= OP_ALU_FIRST && op <= OP_ALU_LAST) begin
            d.cls = CLS_ALU;
            for (int f = 0; f < FAM_COUNT; f++) begin
                if (rel >= OP_W'(f * FORM_COUNT)) begin
                    d.fam  = op_fam_t'(3'(f));
                    d.form = op_form_t'(3'(rel - OP_W'(f * FORM_COUNT)));
                end
            end
            d.need_d = (d.form == FORM_RI) || (d.form == FORM_RR) || (d.form == FORM_RA);
            d.need_s = (d.form == FORM_RR) || (d.form == FORM_AR);
        end else begin
            unique case (op)
                OP_INC_R: begin
                    d.cls    = CLS_INC_R;
                    d.need_d = 1'b1;
                end
                OP_DEC_R: begin
                    d.cls    = CLS_DEC_R;
                    d.need_d = 1'b1;
                end
                OP_INC_A: d.cls = CLS_INC_A;
                OP_DEC_A: d.cls = CLS_DEC_A;
                OP_SET_F: d.cls = CLS_SET_F;
                OP_CLR_F: d.cls = CLS_CLR_F;
                OP_JMP_ABS_R: begin
                    d.cls    = CLS_JMP_ABS;
                    d.jsrc   = JSRC_REG;
                    d.need_s = 1'b1;
                end
                OP_JMP_ABS_I: d.cls = CLS_JMP_ABS;
                OP_JMP_ABS_A: begin
                    d.cls  = CLS_JMP_ABS;
                    d.jsrc = JSRC_ACC;
                end
                OP_JMP_REL_R: begin
                    d.cls    = CLS_JMP_REL;
                    d.jsrc   = JSRC_REG;
                    d.need_s = 1'b1;
                end
                OP_JMP_REL_I: d.cls = CLS_JMP_REL;
                OP_JMP_REL_A: begin
                    d.cls  = CLS_JMP_REL;
                    d.jsrc = JSRC_ACC;
                end
                default: d.cls = CLS_NOP;
            endcase
        end
        return d;
    endfunction

endpackage

### src/pac_regfile.sv
// ----------------------------------------------------------------------------
// pac_regfile
// Register file memory with two registered read ports, one write port,
// per-entry valid bits for reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
module pac_regfile #(
    parameter int REG_COUNT = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [pac_pkg::IDX_W-1:0]  rd_addr_a,
    input  logic [pac_pkg::IDX_W-1:0]  rd_addr_b,
    input  pac_pkg::rf_wr_t            wr,
    output logic [pac_pkg::DATA_W-1:0] rd_data_a,
    output logic [pac_pkg::DATA_W-1:0] rd_data_b
);
    import pac_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    logic [DATA_W-1:0]    mem_reg [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;
    logic                 hit_a;
    logic                 hit_b;
    logic                 ok_a;
    logic                 ok_b;

    assign hit_a = wr.en && (wr.addr == rd_addr_a);
    assign hit_b = wr.en && (wr.addr == rd_addr_b);
    assign ok_a  = rd_addr_a < IDX_W'(REG_COUNT);
    assign ok_b  = rd_addr_b < IDX_W'(REG_COUNT);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (hit_a) begin
                rd_a_reg <= wr.data;
            end else if (ok_a && vld_reg[rd_addr_a[AW-1:0]]) begin
                rd_a_reg <= mem_reg[rd_addr_a[AW-1:0]];
            end else begin
                rd_a_reg <= '0;
            end
            if (hit_b) begin
                rd_b_reg <= wr.data;
            end else if (ok_b && vld_reg[rd_addr_b[AW-1:0]]) begin
                rd_b_reg <= mem_reg[rd_addr_b[AW-1:0]];
            end else begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### src/pac_exec.sv
// ----------------------------------------------------------------------------
// pac_exec
// Execute stage: predicate test, operand selection, ALU, compare, jump
// target and program range check for one instruction.
// ----------------------------------------------------------------------------
module pac_exec #(
    parameter int REG_COUNT = 16
) (
    input  pac_pkg::item_t             item,
    input  logic [pac_pkg::DATA_W-1:0] dest_rd,
    input  logic [pac_pkg::DATA_W-1:0] src_rd,
    input  pac_pkg::arch_t             cur,
    input  logic [pac_pkg::LEN_W-1:0]  len_eff,
    output pac_pkg::exec_out_t         eo
);
    import pac_pkg::*;

    dec_t              dec;
    logic              d_ok;
    logic              s_ok;
    logic              start_out;
    logic              run;
    logic              exe;
    logic              bad;
    logic              go;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] alu_r;
    logic              cmp;
    logic [DATA_W-1:0] jv;
    logic [NIP_W-1:0]  nip;
    logic              nip_out;

    assign dec       = pac_decode(item.opcode);
    assign d_ok      = item.dest_index < IDX_W'(REG_COUNT);
    assign s_ok      = item.source_index < IDX_W'(REG_COUNT);
    assign start_out = {1'b0, cur.ip} >= len_eff;
    assign run       = ((item.allow_flag_mask == '0) || |(cur.flags & item.allow_flag_mask))
                       && !(|(cur.flags & item.deny_flag_mask));
    assign exe       = run && (dec.cls != CLS_NOP);
    assign bad       = (dec.need_d && !d_ok) || (dec.need_s && !s_ok);
    assign go        = exe && !bad;

    always_comb begin
        unique case (dec.form)
            FORM_RI: begin
                opa = dest_rd;
                opb = item.immediate;
            end
            FORM_RR: begin
                opa = dest_rd;
                opb = src_rd;
            end
            FORM_RA: begin
                opa = dest_rd;
                opb = cur.acc;
            end
            FORM_AR: begin
                opa = cur.acc;
                opb = src_rd;
            end
            default: begin
                opa = cur.acc;
                opb = item.immediate;
            end
        endcase
    end

    always_comb begin
        alu_r = opb;
        cmp   = 1'b0;
        unique case (dec.fam)
            FAM_MOV: alu_r = opb;
            FAM_ADD: alu_r = opa + opb;
            FAM_SUB: alu_r = opa - opb;
            FAM_EQ:  cmp = (opa == opb);
            FAM_NE:  cmp = (opa != opb);
            FAM_GT:  cmp = (opa > opb);
            FAM_LT:  cmp = (opa < opb);
            default: cmp = 1'b0;
        endcase
    end

    always_comb begin
        unique case (dec.jsrc)
            JSRC_REG: jv = src_rd;
            JSRC_ACC: jv = cur.acc;
            default:  jv = item.immediate;
        endcase
    end

    always_comb begin
        nip = {2'b00, cur.ip} + NIP_W'(1);
        if (go && dec.cls == CLS_JMP_ABS) begin
            nip = {2'b00, jv};
        end else if (go && dec.cls == CLS_JMP_REL) begin
            nip = {2'b00, cur.ip} + {{2{jv[DATA_W-1]}}, jv};
        end
    end

    // The top bit of the new address is set only when a backward jump went below zero.
    assign nip_out = nip[NIP_W-1] || (nip[LEN_W-1:0] >= len_eff);

    always_comb begin
        eo.nxt     = cur;
        eo.wr.en   = 1'b0;
        eo.wr.addr = item.dest_index;
        eo.wr.data = alu_r;
        if (!cur.halted && !cur.error) begin
            if (start_out) begin
                eo.nxt.halted = 1'b1;
            end else begin
                if (exe && bad) begin
                    eo.nxt.error = 1'b1;
                end
                if (go) begin
                    unique case (dec.cls)
                        CLS_ALU: begin
                            if (dec.fam == FAM_MOV || dec.fam == FAM_ADD ||
                                dec.fam == FAM_SUB) begin
                                if (dec.form == FORM_AR || dec.form == FORM_AI) begin
                                    eo.nxt.acc = alu_r;
                                end else begin
                                    eo.wr.en = 1'b1;
                                end
                            end else if (cmp) begin
                                eo.nxt.flags = cur.flags | item.target_flag_mask;
                            end else begin
                                eo.nxt.flags = cur.flags & ~item.target_flag_mask;
                            end
                        end
                        CLS_INC_R: begin
                            eo.wr.en   = 1'b1;
                            eo.wr.data = dest_rd + DATA_W'(1);
                        end
                        CLS_DEC_R: begin
                            eo.wr.en   = 1'b1;
                            eo.wr.data = dest_rd - DATA_W'(1);
                        end
                        CLS_INC_A: eo.nxt.acc = cur.acc + DATA_W'(1);
                        CLS_DEC_A: eo.nxt.acc = cur.acc - DATA_W'(1);
                        CLS_SET_F: eo.nxt.flags = cur.flags | item.target_flag_mask;
                        CLS_CLR_F: eo.nxt.flags = cur.flags & ~item.target_flag_mask;
                        default: eo.wr.en = 1'b0;
                    endcase
                end
                eo.nxt.ip = nip[IP_W-1:0];
                if (nip_out) begin
                    eo.nxt.halted = 1'b1;
                end
            end
        end
        eo.res.next_ip     = eo.nxt.ip;
        eo.res.halted      = eo.nxt.halted;
        eo.res.error       = eo.nxt.error;
        eo.res.acc_value   = eo.nxt.acc;
        eo.res.flags_value = eo.nxt.flags;
        eo.res.dest_value  = '0;
        if (d_ok) begin
            eo.res.dest_value = eo.wr.en ? eo.wr.data : dest_rd;
        end
    end

endmodule

### src/predicated_accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// predicated_accumulator_cpu_step
// Path: an accepted request is registered in stage 2; its result is then registered for output.
// Throughput: one request per cycle while m_tready is high.
// Reset: state and register file read as zero at once; program length 256.
// ----------------------------------------------------------------------------
`include "predicated_accumulator_cpu_step_assert.svh"

module predicated_accumulator_cpu_step #(
    parameter int REG_COUNT     = 16,
    parameter int PROGRAM_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pac_pkg::LEN_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode[5:0], dest_index[10:6], source_index[15:11], immediate[23:16],
    // target_flag_mask[27:24], allow_flag_mask[31:28], deny_flag_mask[35:32]
    input  logic [pac_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_ip[7:0], halted[8], error[9], acc_value[17:10], flags_value[21:18],
    // dest_value[29:22]
    output logic [pac_pkg::M_TDATA_W-1:0] m_tdata
);
    import pac_pkg::*;

    item_t                 item_in;
    item_t                 item_reg;
    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    arch_t                 arch_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_eff;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic [M_TDATA_W-1:0]  m_data_next;
    logic                  s_accept;
    logic                  adv;
    logic                  stopped;
    logic [DATA_W-1:0]     dest_rd;
    logic [DATA_W-1:0]     src_rd;
    rf_wr_t                rf_wr;
    exec_out_t             eo;

    assign item_in.opcode           = s_tdata[5:0];
    assign item_in.dest_index       = s_tdata[10:6];
    assign item_in.source_index     = s_tdata[15:11];
    assign item_in.immediate        = s_tdata[23:16];
    assign item_in.target_flag_mask = s_tdata[27:24];
    assign item_in.allow_flag_mask  = s_tdata[31:28];
    assign item_in.deny_flag_mask   = s_tdata[35:32];

    assign adv      = s2_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s2_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;
    assign len_eff  = (len_reg > LEN_W'(PROGRAM_DEPTH)) ? LEN_W'(PROGRAM_DEPTH) : len_reg;
    assign stopped  = arch_reg.halted || arch_reg.error;

    pac_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr_a (item_in.dest_index),
        .rd_addr_b (item_in.source_index),
        .wr        (rf_wr),
        .rd_data_a (dest_rd),
        .rd_data_b (src_rd)
    );

    pac_exec #(
        .REG_COUNT (REG_COUNT)
    ) u_exec (
        .item    (item_reg),
        .dest_rd (dest_rd),
        .src_rd  (src_rd),
        .cur     (arch_reg),
        .len_eff (len_eff),
        .eo      (eo)
    );

    always_comb begin
        rf_wr    = eo.wr;
        rf_wr.en = eo.wr.en && adv;
    end

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (s_accept) begin
            s2_valid_next = 1'b1;
        end else if (adv) begin
            s2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        m_data_next = {2'b00, eo.res.dest_value, eo.res.flags_value, eo.res.acc_value,
                       eo.res.error, eo.res.halted, eo.res.next_ip};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            arch_reg     <= '0;
            len_reg      <= LEN_RESET;
        end else begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (adv) begin
                arch_reg <= eo.nxt;
            end
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_in;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PAC_ASSERT_NEXT(a_halt_sticky, aclk, aresetn, arch_reg.halted, arch_reg.halted)
    `PAC_ASSERT_NEXT(a_error_sticky, aclk, aresetn, arch_reg.error, arch_reg.error)
    `PAC_ASSERT_NEXT(a_stopped_frozen, aclk, aresetn, stopped, $stable(arch_reg))
    `PAC_ASSERT_SAME(a_no_result_overrun, aclk, aresetn, adv, (!m_valid_reg || m_tready))
    `PAC_ASSERT_SAME(a_rf_write_on_commit, aclk, aresetn, rf_wr.en, (s2_valid_reg && !stopped))

endmodule

### sim/tb_predicated_accumulator_cpu_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_predicated_accumulator_cpu_step
// Self-checking bench for the predicated accumulator step block. A shadow
// machine inside a small scoreboard class predicts every step result from the
// accepted requests; results are compared field by field in order. A directed
// opening pass is followed by random phases at several program lengths, in
// which requests that would stop the machine are redrawn, and the run ends
// with one randomly chosen way of halting or faulting the machine.
// ----------------------------------------------------------------------------
module tb_predicated_accumulator_cpu_step;
    import pac_pkg::*;

    localparam int REG_COUNT      = 16;
    localparam int PROGRAM_DEPTH  = 256;
    localparam int WATCHDOG_LIMIT = 400;

    localparam logic [OP_W-1:0] OP_NOP          = 6'd0;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 6'd48;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 6'd63;

    typedef enum int {
        END_BAD_INDEX,
        END_JUMP_BELOW,
        END_START_OUTSIDE,
        END_ZERO_LENGTH,
        END_WRAP,
        END_BOTH
    } ending_t;

    typedef struct packed {
        logic [REG_COUNT-1:0][DATA_W-1:0] regs;
        logic [DATA_W-1:0]                acc;
        logic [FLAG_W-1:0]                flags;
        logic [IP_W-1:0]                  ip;
        logic                             halted;
        logic                             error;
        logic [LEN_W-1:0]                 prog_len;
    } machine_t;

    class cpu_step_scoreboard;
        machine_t arch;
        out_t     expected_steps[$];
        int       mismatches;
        int       results_seen;

        function new();
            arch          = '0;
            arch.prog_len = LEN_RESET;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] value);
            arch.prog_len = value;
        endfunction

        function out_t execute(inout machine_t m, input item_t it);
            int         len;
            int         nip;
            int         rel;
            bit         run;
            bit         need_d;
            bit         need_s;
            bit         cond;
            op_fam_t    fam;
            op_form_t   form;
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] r;
            logic [7:0] off;
            out_t       res;
            len = (int'(m.prog_len) > PROGRAM_DEPTH) ? PROGRAM_DEPTH : int'(m.prog_len);
            if (!m.halted && !m.error && int'(m.ip) >= len) begin
                m.halted = 1'b1;
            end
            if (!m.halted && !m.error) begin
                nip    = int'(m.ip) + 1;
                run    = (it.allow_flag_mask == 0 || (m.flags & it.allow_flag_mask) != 0) &&
                         !(it.deny_flag_mask != 0 && (m.flags & it.deny_flag_mask) != 0);
                need_d = 1'b0;
                need_s = 1'b0;
                fam    = FAM_MOV;
                form   = FORM_RI;
                if (it.opcode >= OP_ALU_FIRST && it.opcode <= OP_ALU_LAST) begin
                    rel    = int'(it.opcode) - int'(OP_ALU_FIRST);
                    fam    = op_fam_t'(3'(rel / FORM_COUNT));
                    form   = op_form_t'(3'(rel % FORM_COUNT));
                    need_d = (form == FORM_RI) || (form == FORM_RR) || (form == FORM_RA);
                    need_s = (form == FORM_RR) || (form == FORM_AR);
                end else if (it.opcode == OP_INC_R || it.opcode == OP_DEC_R) begin
                    need_d = 1'b1;
                end else if (it.opcode == OP_JMP_ABS_R || it.opcode == OP_JMP_REL_R) begin
                    need_s = 1'b1;
                end
                if (run && it.opcode >= OP_ALU_FIRST && it.opcode <= OP_JMP_REL_A) begin
                    if ((need_d && it.dest_index >= REG_COUNT) ||
                            (need_s && it.source_index >= REG_COUNT)) begin
                        m.error = 1'b1;
                    end else if (it.opcode <= OP_ALU_LAST) begin
                        if (form == FORM_AR || form == FORM_AI) begin
                            a = m.acc;
                            b = (form == FORM_AR) ? m.regs[it.source_index[3:0]] : it.immediate;
                        end else begin
                            a = m.regs[it.dest_index[3:0]];
                            b = (form == FORM_RI) ? it.immediate :
                                (form == FORM_RR) ? m.regs[it.source_index[3:0]] : m.acc;
                        end
                        if (fam == FAM_MOV || fam == FAM_ADD || fam == FAM_SUB) begin
                            r = (fam == FAM_MOV) ? b : (fam == FAM_ADD) ? a + b : a - b;
                            if (form == FORM_AR || form == FORM_AI) begin
                                m.acc = r;
                            end else begin
                                m.regs[it.dest_index[3:0]] = r;
                            end
                        end else begin
                            cond = (fam == FAM_EQ) ? (a == b) : (fam == FAM_NE) ? (a != b) :
                                   (fam == FAM_GT) ? (a > b) : (a < b);
                            m.flags = cond ? (m.flags | it.target_flag_mask) :
                                             (m.flags & ~it.target_flag_mask);
                        end
                    end else begin
                        unique case (it.opcode)
                            OP_INC_R: m.regs[it.dest_index[3:0]] = m.regs[it.dest_index[3:0]] + 8'd1;
                            OP_DEC_R: m.regs[it.dest_index[3:0]] = m.regs[it.dest_index[3:0]] - 8'd1;
                            OP_INC_A: m.acc = m.acc + 8'd1;
                            OP_DEC_A: m.acc = m.acc - 8'd1;
                            OP_SET_F: m.flags = m.flags | it.target_flag_mask;
                            OP_CLR_F: m.flags = m.flags & ~it.target_flag_mask;
                            OP_JMP_ABS_R: nip = int'(m.regs[it.source_index[3:0]]);
                            OP_JMP_ABS_I: nip = int'(it.immediate);
                            OP_JMP_ABS_A: nip = int'(m.acc);
                            default: begin
                                off = (it.opcode == OP_JMP_REL_R) ? m.regs[it.source_index[3:0]] :
                                      (it.opcode == OP_JMP_REL_I) ? it.immediate : m.acc;
                                nip = int'(m.ip) + int'($signed(off));
                            end
                        endcase
                    end
                end
                if (nip < 0 || nip >= len) begin
                    m.halted = 1'b1;
                end
                m.ip = 8'(nip);
            end
            res.next_ip     = m.ip;
            res.halted      = m.halted;
            res.error       = m.error;
            res.acc_value   = m.acc;
            res.flags_value = m.flags;
            res.dest_value  = (it.dest_index < REG_COUNT) ? m.regs[it.dest_index[3:0]] : 8'd0;
            return res;
        endfunction

        function bit would_stop(item_t it);
            machine_t trial;
            out_t     res;
            trial = arch;
            res   = execute(trial, it);
            return res.halted || res.error;
        endfunction

        function void note_request(logic [S_TDATA_W-1:0] tdata);
            item_t it;
            it.opcode           = tdata[5:0];
            it.dest_index       = tdata[10:6];
            it.source_index     = tdata[15:11];
            it.immediate        = tdata[23:16];
            it.target_flag_mask = tdata[27:24];
            it.allow_flag_mask  = tdata[31:28];
            it.deny_flag_mask   = tdata[35:32];
            expected_steps.push_back(execute(arch, it));
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch on result %0d, %s: got %0h, expected %0h",
                     results_seen, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] tdata);
            out_t want;
            results_seen++;
            if (expected_steps.size() == 0) begin
                report_mismatch("result without request", int'(tdata), 0);
            end else begin
                want = expected_steps.pop_front();
                if (tdata[7:0] != want.next_ip)
                    report_mismatch("next_ip", tdata[7:0], want.next_ip);
                if (tdata[8] != want.halted)
                    report_mismatch("halted", tdata[8], want.halted);
                if (tdata[9] != want.error)
                    report_mismatch("error", tdata[9], want.error);
                if (tdata[17:10] != want.acc_value)
                    report_mismatch("acc_value", tdata[17:10], want.acc_value);
                if (tdata[21:18] != want.flags_value)
                    report_mismatch("flags_value", tdata[21:18], want.flags_value);
                if (tdata[29:22] != want.dest_value)
                    report_mismatch("dest_value", tdata[29:22], want.dest_value);
            end
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [LEN_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    cpu_step_scoreboard sb;
    bit                 calm;
    int                 idle_cycles;

    always #6 aclk = ~aclk;

    predicated_accumulator_cpu_step u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    function automatic logic [OP_W-1:0] alu_op(op_fam_t fam, op_form_t form);
        return OP_ALU_FIRST + OP_W'(int'(fam) * FORM_COUNT + int'(form));
    endfunction

    function automatic item_t mk(logic [OP_W-1:0] op, int d, int s, int imm,
                                 int tmask, int amask, int dmask);
        item_t it;
        it.opcode           = op;
        it.dest_index       = 5'(d);
        it.source_index     = 5'(s);
        it.immediate        = 8'(imm);
        it.target_flag_mask = 4'(tmask);
        it.allow_flag_mask  = 4'(amask);
        it.deny_flag_mask   = 4'(dmask);
        return it;
    endfunction

    function automatic item_t random_item(bit any_index);
        item_t it;
        int    pick;
        it.opcode = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 47)) :
                                                 6'($urandom_range(0, 63));
        it.dest_index   = (any_index || $urandom_range(0, 7) == 0) ?
                          5'($urandom_range(0, 31)) : 5'($urandom_range(0, 15));
        it.source_index = (any_index || $urandom_range(0, 7) == 0) ?
                          5'($urandom_range(0, 31)) : 5'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        it.immediate = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : (pick == 2) ? 8'h7F :
                       (pick == 3) ? 8'h80 : 8'($urandom_range(0, 255));
        it.target_flag_mask = 4'($urandom_range(0, 15));
        it.allow_flag_mask  = $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(0, 15));
        it.deny_flag_mask   = $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(0, 15));
        return it;
    endfunction

    // An unconditional jump to address zero, always inside the program.
    function automatic item_t return_to_origin();
        return mk(OP_JMP_ABS_I, $urandom_range(0, 31), $urandom_range(0, 31), 0,
                  $urandom_range(0, 15), 0, 0);
    endfunction

    // Entered and left at a falling edge.
    task automatic drive_request(item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.deny_flag_mask, it.allow_flag_mask, it.target_flag_mask,
                     it.immediate, it.source_index, it.dest_index, it.opcode};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (sb.expected_steps.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_program_length(logic [LEN_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_length(value);
        @(negedge aclk);
    endtask

    task automatic run_phase(logic [LEN_W-1:0] prog_len, int count);
        item_t it;
        int    tries;
        drive_request(return_to_origin());
        wait_for_drain();
        write_program_length(prog_len);
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            it    = random_item(1'b0);
            tries = 0;
            while (sb.would_stop(it) && tries < 16) begin
                it = random_item(1'b0);
                tries++;
            end
            if (sb.would_stop(it)) it = return_to_origin();
            drive_request(it);
        end
    endtask

    task automatic run_ending();
        ending_t kind;
        kind = ending_t'($urandom_range(0, 5));
        calm = 1'b0;
        drive_request(return_to_origin());
        unique case (kind)
            END_BAD_INDEX: begin
                drive_request(mk(OP_INC_R, $urandom_range(16, 31), 0, 0, 0, 0, 0));
            end
            END_JUMP_BELOW: begin
                drive_request(mk(OP_JMP_REL_I, 0, 0, 8'hFF, 0, 0, 0));
            end
            END_START_OUTSIDE: begin
                drive_request(mk(OP_JMP_ABS_I, 0, 0, 50, 0, 0, 0));
                wait_for_drain();
                write_program_length(9'd10);
                drive_request(random_item(1'b0));
            end
            END_ZERO_LENGTH: begin
                wait_for_drain();
                write_program_length(9'd0);
                drive_request(random_item(1'b0));
            end
            END_WRAP: begin
                drive_request(mk(OP_JMP_ABS_I, 0, 0, 8'hFF, 0, 0, 0));
                drive_request(mk(OP_NOP, 0, 0, 0, 0, 0, 0));
            end
            default: begin
                drive_request(mk(OP_JMP_ABS_I, 0, 0, 8'hFF, 0, 0, 0));
                drive_request(mk(OP_DEC_R, 0, $urandom_range(0, 15), 0, 0, 0, 0));
                drive_request(mk(alu_op(FAM_ADD, FORM_AR), 0, $urandom_range(16, 31),
                                 0, 0, 0, 0));
            end
        endcase
        repeat (24) drive_request(random_item(1'b1));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        sb          = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        drive_request(mk(alu_op(FAM_MOV, FORM_RI), 0, 0, 8'hFF, 0, 0, 0));
        drive_request(mk(alu_op(FAM_MOV, FORM_RI), 15, 0, 8'h80, 0, 0, 0));
        drive_request(mk(alu_op(FAM_ADD, FORM_RR), 0, 15, 0, 0, 0, 0));
        drive_request(mk(alu_op(FAM_MOV, FORM_AI), 31, 31, 8'hFF, 0, 0, 0));
        drive_request(mk(alu_op(FAM_MOV, FORM_RA), 3, 0, 0, 0, 0, 0));
        drive_request(mk(alu_op(FAM_MOV, FORM_AR), 0, 15, 0, 0, 0, 0));
        drive_request(mk(alu_op(FAM_SUB, FORM_AI), 0, 0, 8'hFF, 0, 0, 0));
        drive_request(mk(alu_op(FAM_SUB, FORM_RA), 1, 0, 0, 0, 0, 0));
        drive_request(mk(alu_op(FAM_ADD, FORM_AR), 0, 0, 0, 0, 0, 0));
        drive_request(mk(alu_op(FAM_EQ, FORM_RI), 0, 0, 8'h7F, 4'h1, 0, 0));
        drive_request(mk(alu_op(FAM_NE, FORM_RR), 0, 3, 0, 4'h2, 0, 0));
        drive_request(mk(alu_op(FAM_GT, FORM_RA), 3, 0, 0, 4'h4, 0, 0));
        drive_request(mk(alu_op(FAM_LT, FORM_AI), 0, 0, 8'hFF, 4'h8, 0, 0));
        drive_request(mk(OP_SET_F, 0, 0, 0, 4'hF, 0, 0));
        drive_request(mk(OP_CLR_F, 0, 0, 0, 4'h5, 0, 0));
        drive_request(mk(OP_INC_R, 15, 0, 0, 0, 0, 0));
        drive_request(mk(OP_DEC_R, 1, 0, 0, 0, 0, 0));
        drive_request(mk(OP_DEC_A, 0, 0, 0, 0, 0, 0));
        drive_request(mk(OP_INC_A, 0, 0, 0, 0, 4'h2, 4'h1));
        drive_request(mk(OP_INC_A, 0, 0, 0, 0, 4'h1, 0));
        drive_request(mk(OP_INC_A, 0, 0, 0, 0, 0, 4'h2));
        drive_request(mk(OP_INC_R, 31, 31, 0, 0, 4'h5, 0));
        drive_request(mk(OP_UNUSED_LAST, 7, 7, 8'hAA, 4'hF, 0, 0));
        drive_request(mk(OP_UNUSED_FIRST, 2, 2, 8'h55, 4'hF, 0, 0));
        drive_request(mk(alu_op(FAM_MOV, FORM_RI), 2, 0, 8'h05, 0, 0, 0));
        drive_request(mk(OP_JMP_ABS_I, 0, 0, 200, 0, 0, 0));
        drive_request(mk(OP_JMP_REL_I, 0, 0, 8'hF0, 0, 0, 0));
        drive_request(mk(OP_JMP_REL_R, 0, 2, 0, 0, 0, 0));
        drive_request(mk(OP_JMP_ABS_R, 0, 2, 0, 0, 0, 0));
        drive_request(mk(alu_op(FAM_MOV, FORM_AI), 0, 0, 8'h90, 0, 0, 0));
        drive_request(mk(OP_JMP_ABS_A, 0, 0, 0, 0, 0, 0));
        drive_request(mk(OP_JMP_REL_A, 0, 0, 0, 0, 0, 0));

        run_phase(9'd256, 250);
        run_phase(9'd1, 40);
        run_phase(9'd2, 150);
        run_phase(9'd37, 300);
        run_phase(9'd200, 250);
        run_phase(9'd128, 300);
        run_phase(9'd255, 250);
        run_phase(9'd256, 150);
        run_ending();

        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_steps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
